// ----- rtl/tma_pkg.sv -----
// Shared opcodes and transaction types for the transform matrix accumulator.
package tma_pkg;

   typedef enum logic [2:0] {
      OP_IDENTITY  = 3'd0,
      OP_TRANSLATE = 3'd1,
      OP_ROT_X     = 3'd2,
      OP_ROT_Y     = 3'd3,
      OP_ROT_Z     = 3'd4,
      OP_READ      = 3'd5
   } op_type;

   localparam int ELEM_W = 32;
   localparam int ANGLE_W = 18;

   // Operands of one transform transaction, coefficients widened to element width.
   typedef struct packed {
      logic [2:0]               op;
      logic signed [ELEM_W-1:0] tx;
      logic signed [ELEM_W-1:0] ty;
      logic signed [ELEM_W-1:0] tz;
      logic signed [ELEM_W-1:0] cos_c;
      logic signed [ELEM_W-1:0] sin_c;
   } xform_type;

   typedef logic [3:0][ELEM_W-1:0] row_type;

endpackage

// ----- rtl/tma_row.sv -----
// One matrix row times a translation or axis rotation, rounded and saturated.
module tma_row #(
   parameter int FRAC_BITS = 16
) (
   input  tma_pkg::xform_type xform,
   input  tma_pkg::row_type   row_cur,
   output tma_pkg::row_type   row_new,
   output logic               sat
);

   localparam int PW = 2 * tma_pkg::ELEM_W;
   localparam int SW = PW + 2;
   localparam logic signed [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);
   localparam logic signed [SW-1:0] S32_MAX = SW'(32'h7fff_ffff);
   localparam logic signed [SW-1:0] S32_MIN = -SW'(33'h0_8000_0000);

   logic signed [tma_pkg::ELEM_W-1:0] m [4];
   logic signed [tma_pkg::ELEM_W-1:0] sin_neg;
   logic signed [tma_pkg::ELEM_W-1:0] mul_a [4];
   logic signed [tma_pkg::ELEM_W-1:0] mul_b [4];
   logic signed [PW-1:0]              prod [4];
   logic signed [PW-1:0]              prod_rnd [4];
   logic signed [SW-1:0]              sum_a;
   logic signed [SW-1:0]              sum_b;
   logic                              sat_a;
   logic                              sat_b;
   logic signed [tma_pkg::ELEM_W-1:0] res_a;
   logic signed [tma_pkg::ELEM_W-1:0] res_b;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         m[k] = row_cur[k];
      end
   end

   assign sin_neg = -xform.sin_c;

   // Operand steering: sum_a = p0 + p1 (+ p2 + m3 on translate), sum_b = p2 + p3
   always_comb begin
      mul_a[0] = m[0];
      mul_a[1] = m[1];
      mul_a[2] = m[2];
      mul_a[3] = m[2];
      mul_b[0] = xform.cos_c;
      mul_b[1] = xform.sin_c;
      mul_b[2] = sin_neg;
      mul_b[3] = xform.cos_c;
      case (xform.op)
         tma_pkg::OP_TRANSLATE: begin
            mul_b[0] = xform.tx;
            mul_b[1] = xform.ty;
            mul_b[2] = xform.tz;
         end
         tma_pkg::OP_ROT_X: begin
            mul_a[0] = m[1];
            mul_a[1] = m[2];
            mul_a[2] = m[1];
         end
         tma_pkg::OP_ROT_Y: begin
            mul_b[1] = sin_neg;
            mul_b[2] = xform.sin_c;
            mul_a[2] = m[0];
            mul_a[1] = m[2];
         end
         tma_pkg::OP_ROT_Z: begin
            mul_a[2] = m[0];
            mul_a[3] = m[1];
         end
         default: begin
         end
      endcase
   end

   // Products rounded half up (floor after adding half an LSB)
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         prod[k]     = mul_a[k] * mul_b[k];
         prod_rnd[k] = (prod[k] + HALF) >>> FRAC_BITS;
      end
   end

   always_comb begin
      sum_a = SW'(prod_rnd[0]) + SW'(prod_rnd[1]);
      if (xform.op == tma_pkg::OP_TRANSLATE) begin
         sum_a = sum_a + SW'(prod_rnd[2]) + SW'(m[3]);
      end
      sum_b = SW'(prod_rnd[2]) + SW'(prod_rnd[3]);
   end

   always_comb begin
      sat_a = 1'b0;
      res_a = sum_a[tma_pkg::ELEM_W-1:0];
      if (sum_a > S32_MAX) begin
         sat_a = 1'b1;
         res_a = S32_MAX[tma_pkg::ELEM_W-1:0];
      end else if (sum_a < S32_MIN) begin
         sat_a = 1'b1;
         res_a = S32_MIN[tma_pkg::ELEM_W-1:0];
      end
      sat_b = 1'b0;
      res_b = sum_b[tma_pkg::ELEM_W-1:0];
      if (sum_b > S32_MAX) begin
         sat_b = 1'b1;
         res_b = S32_MAX[tma_pkg::ELEM_W-1:0];
      end else if (sum_b < S32_MIN) begin
         sat_b = 1'b1;
         res_b = S32_MIN[tma_pkg::ELEM_W-1:0];
      end
   end

   // Untouched elements pass through exactly (copied from row_cur, not multiplied)
   always_comb begin
      row_new = row_cur;
      sat     = 1'b0;
      case (xform.op)
         tma_pkg::OP_TRANSLATE: begin
            row_new[3] = res_a;
            sat        = sat_a;
         end
         tma_pkg::OP_ROT_X: begin
            row_new[1] = res_a;
            row_new[2] = res_b;
            sat        = sat_a | sat_b;
         end
         tma_pkg::OP_ROT_Y: begin
            row_new[0] = res_a;
            row_new[2] = res_b;
            sat        = sat_a | sat_b;
         end
         tma_pkg::OP_ROT_Z: begin
            row_new[0] = res_a;
            row_new[1] = res_b;
            sat        = sat_a | sat_b;
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- rtl/transform_matrix_accumulator.sv -----
// Top level: 4x4 fixed-point transform matrix updated by one command per transaction.
//
//   channel   prefix  direction  handshake        payload
//   request   req_    in         req_valid/stall  opcode, offsets, cos, sin, index
//   response  rsp_    out        rsp_valid/stall  element_value, saturated
//
// A transaction lands in the input register, the sixteen elements are recomputed
// in one pass (one 32x32 multiply level per row unit) and the matrix and result
// register load together once the response side is open. Throughput is one
// transaction per cycle while the response is not stalled; the matrix register
// feeds back only one stage, so consecutive commands see each other's updates
// without bubbles. A stalled response holds the result; the input register still
// takes one more transaction, after which req_stall follows rsp_stall.
// Synchronous reset loads the identity matrix and empties both stages.
module transform_matrix_accumulator #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_opcode,
   input  logic signed [31:0] req_offset_x,
   input  logic signed [31:0] req_offset_y,
   input  logic signed [31:0] req_offset_z,
   input  logic signed [17:0] req_cos_val,
   input  logic signed [17:0] req_sin_val,
   input  logic [3:0]         req_index,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_element_value,
   output logic               rsp_saturated
);

   localparam int EW = tma_pkg::ELEM_W;
   localparam logic [EW-1:0] ONE = EW'(1) << FRAC_BITS;

   // input stage
   logic                 s1_valid_ff, s1_valid_in;
   tma_pkg::xform_type   xform_ff, xform_in;
   logic [3:0]           index_ff, index_in;

   // state and result stage
   logic [15:0][EW-1:0]  matrix_ff, matrix_in;
   logic [15:0][EW-1:0]  identity;
   logic [15:0][EW-1:0]  matrix_next;
   logic [3:0]           row_sat;
   logic                 sat_next;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [EW-1:0] rsp_value_ff, rsp_value_in;
   logic                 rsp_sat_ff, rsp_sat_in;

   logic                 req_fire;
   logic                 advance;
   logic                 rsp_open;

   assign rsp_open  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && rsp_open;
   assign req_stall = s1_valid_ff && !rsp_open;
   assign req_fire  = req_valid && !req_stall;

   // request register: widen angle terms to element width on the way in
   always_comb begin
      s1_valid_in    = advance ? 1'b0 : s1_valid_ff;
      xform_in       = xform_ff;
      index_in       = index_ff;
      if (req_fire) begin
         s1_valid_in    = 1'b1;
         xform_in.op    = req_opcode;
         xform_in.tx    = req_offset_x;
         xform_in.ty    = req_offset_y;
         xform_in.tz    = req_offset_z;
         xform_in.cos_c = {{(EW-tma_pkg::ANGLE_W){req_cos_val[tma_pkg::ANGLE_W-1]}},
                           req_cos_val};
         xform_in.sin_c = {{(EW-tma_pkg::ANGLE_W){req_sin_val[tma_pkg::ANGLE_W-1]}},
                           req_sin_val};
         index_in       = req_index;
      end
   end

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         identity[i] = (i % 5 == 0) ? ONE : '0;
      end
   end

   // one row unit per matrix row, all four in parallel
   for (genvar r = 0; r < 4; r++) begin : g_row
      tma_pkg::row_type row_new;

      tma_row #(
         .FRAC_BITS (FRAC_BITS)
      ) u_row (
         .xform   (xform_ff),
         .row_cur (matrix_ff[4*r +: 4]),
         .row_new (row_new),
         .sat     (row_sat[r])
      );
   end

   always_comb begin
      matrix_next = matrix_ff;
      sat_next    = 1'b0;
      case (xform_ff.op)
         tma_pkg::OP_IDENTITY: begin
            matrix_next = identity;
         end
         tma_pkg::OP_TRANSLATE, tma_pkg::OP_ROT_X, tma_pkg::OP_ROT_Y,
         tma_pkg::OP_ROT_Z: begin
            matrix_next = {g_row[3].row_new, g_row[2].row_new,
                           g_row[1].row_new, g_row[0].row_new};
            sat_next    = |row_sat;
         end
         default: begin
            // read only, and the unused codes
         end
      endcase
   end

   always_comb begin
      matrix_in    = matrix_ff;
      rsp_valid_in = rsp_open ? 1'b0 : rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_sat_in   = rsp_sat_ff;
      if (advance) begin
         matrix_in    = matrix_next;
         rsp_valid_in = 1'b1;
         rsp_value_in = matrix_next[index_ff];
         rsp_sat_in   = sat_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         matrix_ff    <= identity;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         matrix_ff    <= matrix_in;
      end
   end

   always_ff @(posedge clock) begin
      xform_ff     <= xform_in;
      index_ff     <= index_in;
      rsp_value_ff <= rsp_value_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_element_value = rsp_value_ff;
   assign rsp_saturated     = rsp_sat_ff;

`ifndef SYNTHESIS
   // matrix only moves when a transaction completes its pass
   a_matrix_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(matrix_ff))
      else $error("matrix changed without a transaction");

   // identity load restores the diagonal (checked at elements 0 and 15) and reports no saturation
   a_identity_load: assert property (@(posedge clock) disable iff (reset)
      (advance && xform_ff.op == tma_pkg::OP_IDENTITY)
      |=> (matrix_ff[0] == ONE && matrix_ff[15] == ONE && !rsp_saturated))
      else $error("identity load did not take effect");

   // read-only command leaves matrix untouched and never flags saturation
   a_read_only: assert property (@(posedge clock) disable iff (reset)
      (advance && xform_ff.op == tma_pkg::OP_READ)
      |=> ($stable(matrix_ff) && !rsp_saturated))
      else $error("read-only command modified state");

   // input register back-pressures only while the response is blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled without a blocked response");
`endif

endmodule
